### rtl/core/kdcr_pkg.sv
package kdcr_pkg;

  localparam int TIMER_BITS = 7;

  typedef logic [TIMER_BITS:0] timer_t;

  localparam timer_t TIMER_FLAG = {1'b1, {TIMER_BITS{1'b0}}};
  localparam timer_t TIMER_ZERO = '0;
  localparam timer_t TIMER_ONE  = {{TIMER_BITS{1'b0}}, 1'b1};

  localparam logic [7:0] HOLD_MAX   = 8'hff;
  localparam logic [7:0] HOLD_FIRST = 8'd3;

  typedef enum logic [2:0] {
    ST_NOPRESS = 3'd0,
    ST_PRESS   = 3'd1,
    ST_DOUBLE  = 3'd2,
    ST_KEEP    = 3'd3,
    ST_KEEPED  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    REG_DEBOUNCE     = 3'd0,
    REG_DOUBLE_WIN   = 3'd1,
    REG_FIRST_REPORT = 3'd2,
    REG_HOLD_START   = 3'd3,
    REG_REPEAT       = 3'd4,
    REG_IDLE_LEVEL   = 3'd5
  } cfg_index_t;

  typedef struct packed {
    logic [6:0] debounce_ticks;
    logic [7:0] double_window_ticks;
    logic [6:0] first_report_ticks;
    logic [6:0] hold_start_ticks;
    logic [6:0] repeat_ticks;
    logic       idle_level;
  } cfg_t;

  typedef struct packed {
    logic       emit;
    logic       key_level;
    status_t    key_status;
    logic [5:0] hold_quarters;
  } result_t;

  // fit a 7-bit tick setting to the timer count field
  function automatic logic [TIMER_BITS-1:0] to_count(input logic [6:0] v);
    logic [TIMER_BITS+6:0] ext;
    ext = {{TIMER_BITS{1'b0}}, v};
    return ext[TIMER_BITS-1:0];
  endfunction

endpackage

### rtl/core/key_debounce_click_repeat_unit.sv
// Single push-button handler: one input transfer is one sampling tick of the pin, and each
// tick yields zero or one report (level, status PRESS/DOUBLE/KEEP/KEEPED, held time in
// quarters). It takes one tick per clock cycle unless the output stalls: the tick lands in
// an input register, the debounce, double-click and repeat timers update in one pass of
// logic, and the report sits in an output register until taken. Ticks that give no
// report still pass through the same two stages. Configuration registers reset to their
// defaults; write them only while no tick is in flight, which the block does not enforce.
module key_debounce_click_repeat_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [0] pin_level, [1] hold_claimed
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [0] key_level, [3:1] key_status, [9:4] hold_quarters
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import kdcr_pkg::*;

  cfg_t    cfg;
  result_t result;
  logic    in_valid;
  logic    in_pin;
  logic    in_claimed;
  logic    advance;

  assign cfg_ready = 1'b1;
  assign advance   = in_valid && (!m_tvalid || m_tready);
  assign s_tready  = !in_valid || advance;

  kdcr_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  kdcr_step u_step (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .pin_level    (in_pin),
    .hold_claimed (in_claimed),
    .cfg          (cfg),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_pin     <= s_tdata[0];
      in_claimed <= s_tdata[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= advance && result.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result.emit && (!m_tvalid || m_tready)) begin
      m_tdata <= {6'd0, result.hold_quarters, result.key_status, result.key_level};
    end
  end

  a_no_nopress_report: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[3:1] != ST_NOPRESS)
    else $error("report carries nopress status");

  a_level_pressed: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !$past(m_tvalid && !m_tready) && !$past(cfg_valid)) |->
      m_tdata[0] != cfg.idle_level)
    else $error("report level equals idle level");

  a_quarters_on_repeat: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[9:4] != 6'd0) |->
      (m_tdata[3:1] == ST_KEEP || m_tdata[3:1] == ST_KEEPED))
    else $error("held time on a first report");

endmodule

### rtl/core/kdcr_cfg.sv
module kdcr_cfg (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [2:0]       wr_index,
  input  logic [7:0]       wr_data,
  output kdcr_pkg::cfg_t   cfg
);
  import kdcr_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks      <= 7'd2;
      cfg.double_window_ticks <= 8'd30;
      cfg.first_report_ticks  <= 7'd5;
      cfg.hold_start_ticks    <= 7'd100;
      cfg.repeat_ticks        <= 7'd25;
      cfg.idle_level          <= 1'b1;
    end else if (wr_en) begin
      case (cfg_index_t'(wr_index))
        REG_DEBOUNCE:     cfg.debounce_ticks      <= wr_data[6:0];
        REG_DOUBLE_WIN:   cfg.double_window_ticks <= wr_data;
        REG_FIRST_REPORT: cfg.first_report_ticks  <= wr_data[6:0];
        REG_HOLD_START:   cfg.hold_start_ticks    <= wr_data[6:0];
        REG_REPEAT:       cfg.repeat_ticks        <= wr_data[6:0];
        REG_IDLE_LEVEL:   cfg.idle_level          <= wr_data[0];
        default: ;
      endcase
    end
  end

endmodule

### rtl/core/kdcr_step.sv
module kdcr_step (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic              pin_level,
  input  logic              hold_claimed,
  input  kdcr_pkg::cfg_t    cfg,
  output kdcr_pkg::result_t result
);
  import kdcr_pkg::*;

  timer_t     debounce_count, debounce_count_next;
  timer_t     repeat_count, repeat_count_next;
  logic [7:0] double_window, double_window_next;
  logic [7:0] hold_count, hold_count_next;
  status_t    status_code, status_code_next;
  logic       key_down, key_down_next;
  logic       double_mark, double_mark_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_count <= TIMER_ZERO;
      repeat_count   <= TIMER_ZERO;
      double_window  <= '0;
      hold_count     <= '0;
      status_code    <= ST_NOPRESS;
      key_down       <= 1'b0;
      double_mark    <= 1'b0;
    end else if (advance) begin
      debounce_count <= debounce_count_next;
      repeat_count   <= repeat_count_next;
      double_window  <= double_window_next;
      hold_count     <= hold_count_next;
      status_code    <= status_code_next;
      key_down       <= key_down_next;
      double_mark    <= double_mark_next;
    end
  end

  always_comb begin
    logic pressed;
    pressed             = pin_level != cfg.idle_level;
    debounce_count_next = debounce_count;
    repeat_count_next   = repeat_count;
    double_window_next  = double_window;
    double_mark_next    = double_mark;
    hold_count_next     = hold_count;
    status_code_next    = status_code;
    key_down_next       = key_down;
    result              = '0;

    if (debounce_count[TIMER_BITS-1:0] != '0) debounce_count_next = debounce_count - TIMER_ONE;
    if (repeat_count[TIMER_BITS-1:0] != '0) repeat_count_next = repeat_count - TIMER_ONE;
    if (double_window != '0) double_window_next = double_window - 8'd1;
    else double_mark_next = 1'b0;

    if (pressed) begin
      if (debounce_count_next == TIMER_ZERO) begin
        debounce_count_next = {1'b1, to_count(cfg.debounce_ticks)};
      end else if (debounce_count_next == TIMER_FLAG && !key_down) begin
        key_down_next = 1'b1;
        if (!double_mark_next || double_window_next == '0) begin
          double_mark_next   = 1'b1;
          status_code_next   = ST_PRESS;
          double_window_next = cfg.double_window_ticks;
        end else begin
          status_code_next = ST_DOUBLE;
          double_mark_next = 1'b0;
        end
        repeat_count_next = {1'b0, to_count(cfg.first_report_ticks)};
        hold_count_next   = '0;
      end
    end else if (key_down) begin
      debounce_count_next = TIMER_ZERO;
      repeat_count_next   = TIMER_ZERO;
      key_down_next       = 1'b0;
      status_code_next    = ST_NOPRESS;
    end

    if (key_down_next && repeat_count_next[TIMER_BITS-1:0] == '0) begin
      result.emit       = 1'b1;
      result.key_level  = ~cfg.idle_level;
      result.key_status = status_code_next;
      if (repeat_count_next == TIMER_ZERO) begin
        repeat_count_next    = {1'b1, to_count(cfg.hold_start_ticks)};
        status_code_next     = ST_KEEP;
        hold_count_next      = HOLD_FIRST;
        result.hold_quarters = '0;
      end else begin
        repeat_count_next = {1'b1, to_count(cfg.repeat_ticks)};
        if (hold_count_next != HOLD_MAX) hold_count_next = hold_count_next + 8'd1;
        result.hold_quarters = hold_count_next[7:2];
        if (hold_claimed) status_code_next = ST_KEEPED;
      end
    end
  end

endmodule

### verif/key_report_checker.sv
`timescale 1ns / 1ps

module key_report_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,   // [0] pin_level, [1] hold_claimed
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,   // [0] key_level, [3:1] key_status, [9:4] hold_quarters
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output int          fail_count,
  output int          pending,
  output int          reports_checked,
  output int          cfg_writes
);
  import kdcr_pkg::*;

  localparam timer_t CNT_MASK = TIMER_FLAG - TIMER_ONE;

  typedef struct packed {
    logic       level;
    status_t    status;
    logic [5:0] quarters;
  } key_report_t;

  cfg_t        settings;
  timer_t      deb_timer;
  timer_t      rep_timer;
  logic [7:0]  dbl_window;
  logic [7:0]  hold_cnt;
  status_t     status;
  logic        key_held;
  logic        dbl_mark;
  key_report_t expected_reports[$];

  task automatic report_mismatch(input string what);
    if (fail_count < 40) $display("[%0t] mismatch: %s", $time, what);
    fail_count++;
  endtask

  task automatic clear_key_state();
    settings.debounce_ticks      = 7'd2;
    settings.double_window_ticks = 8'd30;
    settings.first_report_ticks  = 7'd5;
    settings.hold_start_ticks    = 7'd100;
    settings.repeat_ticks        = 7'd25;
    settings.idle_level          = 1'b1;
    deb_timer  = TIMER_ZERO;
    rep_timer  = TIMER_ZERO;
    dbl_window = '0;
    hold_cnt   = '0;
    status     = ST_NOPRESS;
    key_held   = 1'b0;
    dbl_mark   = 1'b0;
    expected_reports.delete();
  endtask

  task automatic apply_reg_write(input logic [2:0] idx, input logic [7:0] val);
    case (cfg_index_t'(idx))
      REG_DEBOUNCE:     settings.debounce_ticks      = val[6:0];
      REG_DOUBLE_WIN:   settings.double_window_ticks = val;
      REG_FIRST_REPORT: settings.first_report_ticks  = val[6:0];
      REG_HOLD_START:   settings.hold_start_ticks    = val[6:0];
      REG_REPEAT:       settings.repeat_ticks        = val[6:0];
      REG_IDLE_LEVEL:   settings.idle_level          = val[0];
      default: ;
    endcase
  endtask

  task automatic advance_key_tick(input logic pin, input logic claimed);
    logic        pressed;
    key_report_t rpt;
    pressed = pin != settings.idle_level;

    if ((deb_timer & CNT_MASK) != TIMER_ZERO) deb_timer = deb_timer - TIMER_ONE;
    if ((rep_timer & CNT_MASK) != TIMER_ZERO) rep_timer = rep_timer - TIMER_ONE;
    if (dbl_window != 8'd0) dbl_window = dbl_window - 8'd1;
    else dbl_mark = 1'b0;

    if (pressed) begin
      if (deb_timer == TIMER_ZERO) begin
        deb_timer = TIMER_FLAG | (timer_t'(settings.debounce_ticks) & CNT_MASK);
      end else if (deb_timer == TIMER_FLAG && !key_held) begin
        key_held = 1'b1;
        if (!dbl_mark || dbl_window == 8'd0) begin
          dbl_mark   = 1'b1;
          status     = ST_PRESS;
          dbl_window = settings.double_window_ticks;
        end else begin
          status   = ST_DOUBLE;
          dbl_mark = 1'b0;
        end
        rep_timer = timer_t'(settings.first_report_ticks) & CNT_MASK;
        hold_cnt  = '0;
      end
    end else if (key_held) begin
      deb_timer = TIMER_ZERO;
      rep_timer = TIMER_ZERO;
      key_held  = 1'b0;
      status    = ST_NOPRESS;
    end

    if (!key_held || (rep_timer & CNT_MASK) != TIMER_ZERO) return;

    rpt.level  = ~settings.idle_level;
    rpt.status = status;
    if (rep_timer == TIMER_ZERO) begin
      rep_timer    = TIMER_FLAG | (timer_t'(settings.hold_start_ticks) & CNT_MASK);
      rpt.quarters = '0;
      status       = ST_KEEP;
      hold_cnt     = HOLD_FIRST;
    end else begin
      rep_timer = TIMER_FLAG | (timer_t'(settings.repeat_ticks) & CNT_MASK);
      if (hold_cnt < HOLD_MAX) hold_cnt = hold_cnt + 8'd1;
      rpt.quarters = hold_cnt[7:2];
      if (claimed) status = ST_KEEPED;
    end
    expected_reports.push_back(rpt);
  endtask

  task automatic check_report(input logic [15:0] data);
    key_report_t want;
    if (expected_reports.size() == 0) begin
      report_mismatch($sformatf("report %h arrived with none expected", data));
      return;
    end
    want = expected_reports.pop_front();
    reports_checked++;
    if (data[0] !== want.level)
      report_mismatch($sformatf("key_level %b, expected %b", data[0], want.level));
    if (data[3:1] !== want.status)
      report_mismatch($sformatf("key_status %0d, expected %s", data[3:1], want.status.name()));
    if (data[9:4] !== want.quarters)
      report_mismatch($sformatf("hold_quarters %0d, expected %0d", data[9:4], want.quarters));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_key_state();
    end else begin
      if (cfg_valid && cfg_ready) begin
        apply_reg_write(cfg_index, cfg_data);
        cfg_writes++;
      end
      if (s_tvalid && s_tready) advance_key_tick(s_tdata[0], s_tdata[1]);
      if (m_tvalid && m_tready) check_report(m_tdata);
    end
    pending = expected_reports.size();
  end

endmodule

### verif/key_debounce_click_repeat_unit_tb.sv
`timescale 1ns / 1ps

module key_debounce_click_repeat_unit_tb;
  import kdcr_pkg::*;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata   = '0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [15:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = REG_DEBOUNCE;
  logic [7:0]  cfg_data  = '0;

  int fail_count;
  int pending;
  int reports_checked;
  int cfg_writes;

  bit cur_idle   = 1'b1;
  bit tx_burst   = 1'b0;
  bit rx_burst   = 1'b0;
  bit stall_go   = 1'b0;
  bit stall_done = 1'b0;
  int ticks_sent = 0;
  int settings_used = 0;

  always #4 clk = ~clk;

  key_debounce_click_repeat_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  key_report_checker checker_i (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending),
    .reports_checked(reports_checked), .cfg_writes(cfg_writes)
  );

  task automatic draw_gap(inout bit burst, output int gap);
    if ($urandom_range(0, 29) == 0) burst = !burst;
    gap = burst ? 0 : $urandom_range(0, 12);
  endtask

  task automatic send_tick(input bit pin, input bit claim);
    int gap;
    draw_gap(tx_burst, gap);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, claim, pin};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    ticks_sent++;
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    if (idx == REG_IDLE_LEVEL) cur_idle = val[0];
  endtask

  task automatic set_config(input logic [7:0] deb, input logic [7:0] dwin,
                            input logic [7:0] first, input logic [7:0] hold,
                            input logic [7:0] rpt, input logic [7:0] idle);
    write_reg(REG_DEBOUNCE, deb);
    write_reg(REG_DOUBLE_WIN, dwin);
    write_reg(REG_FIRST_REPORT, first);
    write_reg(REG_HOLD_START, hold);
    write_reg(REG_REPEAT, rpt);
    write_reg(REG_IDLE_LEVEL, idle);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // hold until every expected report is out and the pipeline has emptied
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic run_episodes(input int n, input int max_press, input int max_gap);
    int stop_at;
    int kind;
    int len;
    stop_at = ticks_sent + n;
    while (ticks_sent < stop_at) begin
      kind = $urandom_range(0, 9);
      if (kind <= 5) begin
        len = $urandom_range(1, max_press);
        repeat (len) send_tick(~cur_idle, 1'($urandom_range(0, 1)));
        len = $urandom_range(1, max_gap);
        repeat (len) send_tick(cur_idle, 1'($urandom_range(0, 1)));
      end else if (kind <= 7) begin
        len = $urandom_range(1, 4);
        repeat (len) send_tick(~cur_idle, 1'($urandom_range(0, 1)));
        len = $urandom_range(1, 3);
        repeat (len) send_tick(cur_idle, 1'($urandom_range(0, 1)));
        len = $urandom_range(2, max_press);
        repeat (len) send_tick(~cur_idle, 1'($urandom_range(0, 1)));
        len = $urandom_range(1, max_gap);
        repeat (len) send_tick(cur_idle, 1'($urandom_range(0, 1)));
      end else begin
        repeat (6) send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    #3_200_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    int gap;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (stall_go && !stall_done) begin
        gap = 300;
        stall_done = 1'b1;
      end else begin
        draw_gap(rx_burst, gap);
      end
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    set_config(8'd0, 8'd255, 8'd0, 8'd1, 8'd1, 8'd1);
    repeat (4) send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b0);
    repeat (3) send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b0);
    drain();

    set_config(8'd3, 8'd0, 8'd2, 8'd2, 8'd1, 8'd1);
    send_tick(1'b0, 1'b0);
    repeat (4) send_tick(1'b1, 1'b0);
    repeat (4) send_tick(1'b0, 1'b1);
    drain();

    // flip the idle level while the key is still held
    write_reg(REG_IDLE_LEVEL, 8'd0);
    cfg_valid <= 1'b0;
    repeat (4) send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b0);
    drain();

    set_config(8'd1, 8'd0, 8'd0, 8'd1, 8'd1, 8'd0);
    run_episodes(60, 12, 6);
    stall_go = 1'b1;
    repeat (280) send_tick(~cur_idle, 1'($urandom_range(0, 1)));
    send_tick(cur_idle, 1'b0);
    drain();

    set_config(8'd127, 8'd255, 8'd127, 8'd127, 8'd127, 8'd1);
    repeat (270) send_tick(~cur_idle, 1'($urandom_range(0, 1)));
    run_episodes(20, 6, 4);
    drain();

    repeat (4) begin
      set_config(8'({1'($urandom_range(0, 1)), 7'($urandom_range(1, 6))}),
                 8'($urandom_range(0, 40)),
                 8'({1'($urandom_range(0, 1)), 7'($urandom_range(0, 6))}),
                 8'({1'($urandom_range(0, 1)), 7'($urandom_range(1, 10))}),
                 8'({1'($urandom_range(0, 1)), 7'($urandom_range(1, 6))}),
                 8'({7'($urandom_range(0, 127)), 1'($urandom_range(0, 1))}));
      run_episodes(25, 24, 8);
      drain();
    end

    repeat (8) @(negedge clk);
    $display("Covered %0d pin ticks under %0d register settings (%0d register writes),",
             ticks_sent, settings_used + 1, cfg_writes);
    $display("with %0d reports checked against the predicted key status and hold time.",
             reports_checked);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
